FILE: rtl/core/cvl_pkg.sv
package cvl_pkg;

  // Default list depth
  localparam int unsigned CapacityDef = 64;

  // Fixed field widths
  localparam int unsigned ModeW   = 2;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned PosW    = 7;

  typedef enum logic [ModeW-1:0] {
    MODE_INSERT = 2'd0,
    MODE_SEARCH = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // Per-cycle commands broadcast to every cell
  typedef struct packed {
    logic cmp;   // load match flag from compare
    logic scan;  // merge flag from the cell at the current scan distance
    logic ins;   // write the broadcast value at the tail cell
    logic del;   // cells at or after the first match take the next entry
  } cell_ctrl_t;

endpackage

FILE: rtl/core/cvl_if.sv
interface cvl_in_if;
  logic                                valid;
  logic                                ready;
  logic        [cvl_pkg::ModeW-1:0]    mode;
  logic signed [cvl_pkg::ValueW-1:0]   value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface cvl_out_if;
  logic                         valid;
  logic                         ready;
  logic [cvl_pkg::StatusW-1:0]  status;
  logic [cvl_pkg::PosW-1:0]     position;
  logic [cvl_pkg::PosW-1:0]     count;

  modport source (output valid, output status, output position, output count, input ready);
  modport sink   (input valid, input status, input position, input count, output ready);
endinterface

FILE: rtl/core/cvl_cell.sv
module cvl_cell #(
  parameter int unsigned CW    = 7,
  parameter int unsigned INDEX = 0
) (
  input  logic                           clk_i,
  input  cvl_pkg::cell_ctrl_t            ctrl_i,
  input  logic [cvl_pkg::ValueW-1:0]     value_i,
  input  logic [CW-1:0]                  count_i,
  input  logic [cvl_pkg::ValueW-1:0]     next_entry_i,
  input  logic                           far_flag_i,
  output logic [cvl_pkg::ValueW-1:0]     entry_o,
  output logic                           flag_o
);

  localparam logic [CW-1:0] MyIdx = CW'(INDEX);

  logic [cvl_pkg::ValueW-1:0] entry_q, entry_d;
  logic                       flag_q, flag_d;
  logic                       occupied;

  assign occupied = (MyIdx < count_i);

  // Entry: append at the tail, or close the gap behind the first match
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins && (count_i == MyIdx)) begin
      entry_d = value_i;
    end else if (ctrl_i.del && flag_q) begin
      entry_d = next_entry_i;
    end
  end

  // Flag: match on compare, then prefix OR over the scan steps
  always_comb begin
    flag_d = flag_q;
    if (ctrl_i.cmp) begin
      flag_d = occupied && (entry_q == value_i);
    end else if (ctrl_i.scan) begin
      flag_d = flag_q | far_flag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    flag_q  <= flag_d;
  end

  assign entry_o = entry_q;
  assign flag_o  = flag_q;

endmodule

FILE: rtl/core/cvl_pos_enc.sv
module cvl_pos_enc #(
  parameter int unsigned CAP = 64,
  parameter int unsigned CW  = 7
) (
  input  logic [CAP-1:0] flag_i,
  output logic [CW-1:0]  pos_o
);

  logic [CAP-1:0] first;

  // Mark the rising edge of the prefix flags
  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      if (i == 0) begin
        first[i] = flag_i[i];
      end else begin
        first[i] = flag_i[i] & ~flag_i[i-1];
      end
    end
  end

  // OR the one-based index of the marked cell
  always_comb begin
    pos_o = '0;
    for (int i = 0; i < CAP; i++) begin
      pos_o = pos_o | ({CW{first[i]}} & CW'(i + 1));
    end
  end

endmodule

FILE: rtl/core/compacting_value_list.sv
// compacting_value_list: ordered list of up to CAP signed 32-bit words.
// Input channel in_i carries mode (insert, search, delete first match,
// clear) and value; output channel out_o returns one item per input item
// with status, one-based position of the first match and the new count.
// Each stored word sits in one cell of a chain; a delete shifts every cell
// after the match down by one place, all together. Insert and clear go
// from the accept to the finish state; search and delete pass the compare
// state and the scan steps first. The finish state loads the output
// register behind out_o.valid. The first-match search is a prefix OR over
// the cell flags that doubles its reach each scan step, and it sets the
// search latency. One item is in work at a time: a new item is taken only
// once the last has finished and the block is back in idle.
// in_i.ready stays high while a result waits in the output register; a
// finished item waits in place until out_o.ready frees that register.
// Reset empties the list (count zero) and drops any pending result; stored
// words need no reset since only counted entries are ever read.
module compacting_value_list #(
  parameter int unsigned CAP = cvl_pkg::CapacityDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  cvl_in_if.sink   in_i,
  cvl_out_if.source out_o
);

  localparam int unsigned CW  = $clog2(CAP + 1);
  localparam int unsigned LVL = $clog2(CAP);
  localparam int unsigned STW = (LVL > 1) ? $clog2(LVL) : 1;
  localparam logic [CW-1:0] CapC = CW'(CAP);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]                  state_q, state_d;
  logic [STW-1:0]              step_q, step_d;
  logic [CW-1:0]               count_q, count_d;
  logic [cvl_pkg::ModeW-1:0]   mode_q;
  logic [cvl_pkg::ValueW-1:0]  value_q;

  logic                        out_valid_q;
  logic [cvl_pkg::StatusW-1:0] out_status_q, status_new;
  logic [cvl_pkg::PosW-1:0]    out_pos_q, out_count_q;
  logic [cvl_pkg::PosW-1:0]    pos_narrow, count_narrow;
  logic [CW+cvl_pkg::PosW-1:0] pos_ext, count_ext;

  logic                        in_fire, done_fire, found;
  logic [CW-1:0]               pos_w;
  cvl_pkg::cell_ctrl_t         ctrl;

  logic [cvl_pkg::ValueW-1:0]  entry   [CAP];
  logic [cvl_pkg::ValueW-1:0]  next_e  [CAP];
  logic [CAP-1:0]              flag;
  logic [CAP-1:0]              far_flag;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign done_fire  = (state_q == S_DONE) && (!out_valid_q || out_o.ready);
  assign found      = flag[CAP-1];

  // Cell commands
  always_comb begin
    ctrl      = '0;
    ctrl.cmp  = (state_q == S_CMP);
    ctrl.scan = (state_q == S_SCAN);
    ctrl.ins  = done_fire && (mode_q == cvl_pkg::MODE_INSERT);
    ctrl.del  = done_fire && (mode_q == cvl_pkg::MODE_DELETE) && found;
  end

  // Pick the flag at the current doubling distance for each cell
  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      far_flag[i] = 1'b0;
      for (int k = 0; k < LVL; k++) begin
        if ((i >= (1 << k)) && (STW'(k) == step_q)) begin
          far_flag[i] = far_flag[i] | flag[i - (1 << k)];
        end
      end
    end
  end

  // Chain of cells, each fed by its upper neighbor on delete (the last by itself)
  for (genvar g = 0; g < CAP; g++) begin : g_cell
    if (g == CAP - 1) begin : g_last
      assign next_e[g] = entry[g];
    end else begin : g_mid
      assign next_e[g] = entry[g+1];
    end

    cvl_cell #(
      .CW    (CW),
      .INDEX (g)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .value_i      (value_q),
      .count_i      (count_q),
      .next_entry_i (next_e[g]),
      .far_flag_i   (far_flag[g]),
      .entry_o      (entry[g]),
      .flag_o       (flag[g])
    );
  end

  cvl_pos_enc #(
    .CAP (CAP),
    .CW  (CW)
  ) u_pos_enc (
    .flag_i (flag),
    .pos_o  (pos_w)
  );

  // Result and new count of the finishing item
  always_comb begin
    status_new = cvl_pkg::ST_DONE;
    count_d    = count_q;
    pos_ext    = '0;
    unique case (cvl_pkg::mode_e'(mode_q))
      cvl_pkg::MODE_INSERT: begin
        if (count_q >= CapC) begin
          status_new = cvl_pkg::ST_FULL;
        end else begin
          count_d = count_q + CW'(1);
        end
      end
      cvl_pkg::MODE_SEARCH, cvl_pkg::MODE_DELETE: begin
        if (count_q == '0) begin
          status_new = cvl_pkg::ST_EMPTY;
        end else if (!found) begin
          status_new = cvl_pkg::ST_NOTFOUND;
        end else begin
          pos_ext = {{cvl_pkg::PosW{1'b0}}, pos_w};
          if (mode_q == cvl_pkg::MODE_DELETE) begin
            count_d = count_q - CW'(1);
          end
        end
      end
      cvl_pkg::MODE_CLEAR: begin
        count_d = '0;
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  assign count_ext    = {{cvl_pkg::PosW{1'b0}}, count_d};
  assign pos_narrow   = pos_ext[cvl_pkg::PosW-1:0];
  assign count_narrow = count_ext[cvl_pkg::PosW-1:0];

  // Sequencer: compare, scan, then finish for search and delete; insert and clear go straight to finish
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if ((in_i.mode == cvl_pkg::MODE_SEARCH) || (in_i.mode == cvl_pkg::MODE_DELETE)) begin
            state_d = S_CMP;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_CMP: begin
        step_d  = '0;
        state_d = (LVL == 0) ? S_DONE : S_SCAN;
      end
      S_SCAN: begin
        if (step_q == STW'(LVL - 1)) begin
          state_d = S_DONE;
        end else begin
          step_d = step_q + STW'(1);
        end
      end
      S_DONE: begin
        if (done_fire) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (done_fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the operands and the result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q  <= in_i.mode;
      value_q <= in_i.value;
    end
    if (done_fire) begin
      out_status_q <= status_new;
      out_pos_q    <= pos_narrow;
      out_count_q  <= count_narrow;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.status   = out_status_q;
  assign out_o.position = out_pos_q;
  assign out_o.count    = out_count_q;

endmodule

FILE: rtl/core/cvl_checker.sv
module cvl_checker #(
  parameter int unsigned CAP = cvl_pkg::CapacityDef
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [cvl_pkg::StatusW-1:0]  out_status_i,
  input logic [cvl_pkg::PosW-1:0]     out_position_i,
  input logic [cvl_pkg::PosW-1:0]     out_count_i
);

  localparam logic [cvl_pkg::PosW-1:0] CapP = cvl_pkg::PosW'(CAP);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i)
      && $stable(out_position_i) && $stable(out_count_i))
    else $error("stalled result changed");

  // Full only when the count sits at capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i == cvl_pkg::ST_FULL) |-> (out_count_i == CapP))
    else $error("full reported below capacity");

  // Empty only with nothing held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i == cvl_pkg::ST_EMPTY) |-> (out_count_i == '0))
    else $error("empty reported with entries held");

  // A position comes only with a hit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_position_i != '0) |-> (out_status_i == cvl_pkg::ST_DONE))
    else $error("position without a match");

  // A hit lies inside the list as it was before the item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ({1'b0, out_position_i} <= ({1'b0, out_count_i} + 8'd1)))
    else $error("position beyond the list");

endmodule

bind compacting_value_list cvl_checker #(
  .CAP (CAP)
) u_cvl_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_status_i   (out_o.status),
  .out_position_i (out_o.position),
  .out_count_i    (out_o.count)
);

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import cvl_pkg::*;

  localparam int unsigned CAP       = CapacityDef;
  localparam int unsigned N_RAND    = 1250;
  localparam int unsigned N_QUIET   = 150;
  localparam int unsigned LIMIT     = 400000;
  localparam int unsigned DRAIN_CYC = 30;
  localparam int unsigned PHASE_LEN = 80;

  typedef enum int unsigned {
    PH_MIXED,
    PH_FILL,
    PH_DRAIN
  } mix_e;

  // One list operation with an optional typed expectation
  typedef struct packed {
    mode_e               mode;
    logic [ValueW-1:0]   value;
    logic [7:0]          reps;
    logic                chk;
    status_e             st;
    logic [PosW-1:0]     pos;
    logic [PosW-1:0]     cnt;
  } list_op_t;

  // Expected result item, tagged with the operation that caused it
  typedef struct packed {
    logic [ModeW-1:0]    mode;
    logic [ValueW-1:0]   value;
    status_e             st;
    logic [PosW-1:0]     pos;
    logic [PosW-1:0]     cnt;
  } list_res_t;

  logic clk_i;
  logic rst_ni;

  cvl_in_if  in_if ();
  cvl_out_if out_if ();

  compacting_value_list #(
    .CAP(CAP)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Directed table: rows with chk set carry the result typed in by hand
  localparam int unsigned N_ROWS = 26;
  list_op_t dir_tbl [N_ROWS] = '{
    '{MODE_SEARCH, 32'h0000_0005, 8'd1,  1'b1, ST_EMPTY,    7'd0,  7'd0},
    '{MODE_DELETE, 32'h0000_0005, 8'd1,  1'b1, ST_EMPTY,    7'd0,  7'd0},
    '{MODE_CLEAR,  32'hDEAD_BEEF, 8'd1,  1'b1, ST_DONE,     7'd0,  7'd0},
    '{MODE_INSERT, 32'h7FFF_FFFF, 8'd1,  1'b1, ST_DONE,     7'd0,  7'd1},
    '{MODE_INSERT, 32'h8000_0000, 8'd1,  1'b1, ST_DONE,     7'd0,  7'd2},
    '{MODE_INSERT, 32'h0000_0000, 8'd1,  1'b1, ST_DONE,     7'd0,  7'd3},
    '{MODE_INSERT, 32'hFFFF_FFFF, 8'd1,  1'b1, ST_DONE,     7'd0,  7'd4},
    '{MODE_SEARCH, 32'h8000_0000, 8'd1,  1'b1, ST_DONE,     7'd2,  7'd4},
    '{MODE_SEARCH, 32'h0000_3039, 8'd1,  1'b1, ST_NOTFOUND, 7'd0,  7'd4},
    '{MODE_INSERT, 32'h7FFF_FFFF, 8'd1,  1'b1, ST_DONE,     7'd0,  7'd5},
    '{MODE_SEARCH, 32'h7FFF_FFFF, 8'd1,  1'b1, ST_DONE,     7'd1,  7'd5},
    '{MODE_DELETE, 32'h7FFF_FFFF, 8'd1,  1'b1, ST_DONE,     7'd1,  7'd4},
    '{MODE_SEARCH, 32'h7FFF_FFFF, 8'd1,  1'b1, ST_DONE,     7'd4,  7'd4},
    '{MODE_DELETE, 32'hFFFF_FFFF, 8'd1,  1'b1, ST_DONE,     7'd3,  7'd3},
    '{MODE_DELETE, 32'h0000_3039, 8'd1,  1'b1, ST_NOTFOUND, 7'd0,  7'd3},
    '{MODE_DELETE, 32'h7FFF_FFFF, 8'd1,  1'b1, ST_DONE,     7'd3,  7'd2},
    '{MODE_CLEAR,  32'h0000_0000, 8'd1,  1'b1, ST_DONE,     7'd0,  7'd0},
    // stale words after a clear must not be found
    '{MODE_SEARCH, 32'h0000_0000, 8'd1,  1'b1, ST_EMPTY,    7'd0,  7'd0},
    // fill to capacity with consecutive words
    '{MODE_INSERT, 32'h0000_1000, 8'd64, 1'b0, ST_DONE,     7'd0,  7'd0},
    '{MODE_INSERT, 32'h0000_0005, 8'd1,  1'b1, ST_FULL,     7'd0,  7'd64},
    '{MODE_SEARCH, 32'h0000_103F, 8'd1,  1'b1, ST_DONE,     7'd64, 7'd64},
    '{MODE_DELETE, 32'h0000_1000, 8'd1,  1'b1, ST_DONE,     7'd1,  7'd63},
    '{MODE_SEARCH, 32'h0000_103F, 8'd1,  1'b1, ST_DONE,     7'd63, 7'd63},
    '{MODE_INSERT, 32'hFFFF_FFFF, 8'd1,  1'b1, ST_DONE,     7'd0,  7'd64},
    '{MODE_DELETE, 32'hFFFF_FFFF, 8'd1,  1'b1, ST_DONE,     7'd64, 7'd63},
    '{MODE_CLEAR,  32'hFFFF_FFFF, 8'd1,  1'b1, ST_DONE,     7'd0,  7'd0}
  };

  logic [ValueW-1:0] word_pool [8] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
    32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_002A
  };

  // Shadow copy of the list
  logic [ValueW-1:0] list_mem [CAP];
  int unsigned       list_cnt;

  list_op_t    dir_q [$];
  list_res_t   exp_q [$];
  list_op_t    cur_op;

  int unsigned n_total;
  int unsigned n_issued;
  int unsigned n_acc;
  int unsigned n_res;
  int unsigned err_cnt;
  int unsigned cyc_cnt;
  int unsigned pause_at;
  bit          paused;
  int unsigned snd_gap;
  int unsigned rcv_gap;
  int unsigned snd_pct;
  int unsigned rcv_pct;
  mix_e        mix_phase;

  // Apply one operation to the shadow list and return its result item
  function automatic list_res_t list_apply(logic [ModeW-1:0] op, logic [ValueW-1:0] val);
    list_res_t r;
    int        hit;
    r.mode  = op;
    r.value = val;
    r.st    = ST_DONE;
    r.pos   = '0;
    hit     = -1;
    case (op)
      MODE_INSERT: begin
        if (list_cnt >= CAP) begin
          r.st = ST_FULL;
        end else begin
          list_mem[list_cnt] = val;
          list_cnt++;
        end
      end
      MODE_SEARCH, MODE_DELETE: begin
        if (list_cnt == 0) begin
          r.st = ST_EMPTY;
        end else begin
          for (int i = 0; i < int'(list_cnt); i++) begin
            if (hit < 0 && list_mem[i] == val) hit = i;
          end
          if (hit < 0) begin
            r.st = ST_NOTFOUND;
          end else begin
            r.pos = PosW'(hit + 1);
            // close the gap behind the first match
            if (op == MODE_DELETE) begin
              for (int i = hit; i + 1 < int'(list_cnt); i++) list_mem[i] = list_mem[i + 1];
              list_cnt--;
            end
          end
        end
      end
      default: list_cnt = 0;
    endcase
    r.cnt = PosW'(list_cnt);
    return r;
  endfunction

  // Draw a random operation, mostly aimed at words the list holds
  function automatic void pick_op(output logic [ModeW-1:0] op, output logic [ValueW-1:0] val);
    int unsigned r;
    int unsigned v;
    r = $urandom_range(0, 99);
    case (mix_phase)
      PH_FILL:  op = (r < 90) ? MODE_INSERT : (r < 95) ? MODE_SEARCH : MODE_DELETE;
      PH_DRAIN: op = (r < 15) ? MODE_INSERT : (r < 35) ? MODE_SEARCH : MODE_DELETE;
      default: begin
        if (r < 40)      op = MODE_INSERT;
        else if (r < 65) op = MODE_SEARCH;
        else if (r < 93) op = MODE_DELETE;
        else if (r < 96) op = MODE_CLEAR;
        else             op = ModeW'($urandom_range(0, 3));
      end
    endcase
    v = $urandom_range(0, 99);
    if (op == MODE_INSERT) begin
      val = (v < 30) ? word_pool[$urandom_range(0, 7)] : $urandom;
    end else if (list_cnt > 0 && v < 60) begin
      val = list_mem[$urandom_range(0, list_cnt - 1)];
    end else if (v < 80) begin
      val = word_pool[$urandom_range(0, 7)];
    end else begin
      val = $urandom;
    end
  endfunction

  function automatic int unsigned pick_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 15;
      default: return 50;
    endcase
  endfunction

  // Clock
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Reset, table expansion and end of run
  initial begin
    list_op_t row;
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.mode    = MODE_INSERT;
    in_if.value   = '0;
    out_if.ready  = 1'b0;
    list_cnt      = 0;
    n_issued      = 0;
    n_acc         = 0;
    n_res         = 0;
    err_cnt       = 0;
    paused        = 1'b0;
    snd_gap       = 0;
    rcv_gap       = 0;
    snd_pct       = 30;
    rcv_pct       = 30;
    mix_phase     = PH_MIXED;
    for (int i = 0; i < CAP; i++) list_mem[i] = '0;
    for (int i = 0; i < N_ROWS; i++) begin
      for (int k = 0; k < int'(dir_tbl[i].reps); k++) begin
        row       = dir_tbl[i];
        row.value = dir_tbl[i].value + ValueW'(k);
        dir_q.push_back(row);
      end
    end
    n_total  = dir_q.size() + N_RAND;
    pause_at = dir_q.size() + N_RAND / 2;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!(n_acc == n_total && exp_q.size() == 0)) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (err_cnt == 0 && exp_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt >= LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end
  initial cyc_cnt = 0;

  // Drive both channels, predict accepted items and check result items
  always @(posedge clk_i) begin
    list_res_t        want;
    list_res_t        pr;
    logic             took;
    logic             quiet;
    logic [ModeW-1:0] nm;
    logic [ValueW-1:0] nv;
    if (rst_ni) begin
      quiet = (n_issued + N_QUIET >= n_total);

      // check the result item taken at this edge
      if (out_if.valid && out_if.ready) begin
        n_res++;
        if (exp_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("result %0d: unexpected item st=%0d pos=%0d cnt=%0d", n_res,
                     out_if.status, out_if.position, out_if.count);
        end else begin
          want = exp_q.pop_front();
          if (out_if.status !== want.st || out_if.position !== want.pos ||
              out_if.count !== want.cnt) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display({"result %0d (mode %0d value %h): exp st=%0d pos=%0d cnt=%0d,",
                        " got st=%0d pos=%0d cnt=%0d"},
                       n_res, want.mode, want.value, want.st, want.pos, want.cnt,
                       out_if.status, out_if.position, out_if.count);
          end
        end
      end

      // stall the result side in bursts
      if (rcv_gap > 0 && !quiet) begin
        rcv_gap--;
        out_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < rcv_pct) begin
        rcv_gap = $urandom_range(0, 13);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end

      // predict the item accepted at this edge
      took = in_if.valid && in_if.ready;
      if (took) begin
        pr = list_apply(cur_op.mode, cur_op.value);
        if (cur_op.chk) begin
          pr.st  = cur_op.st;
          pr.pos = cur_op.pos;
          pr.cnt = cur_op.cnt;
        end
        exp_q.push_back(pr);
        n_acc++;
        if (!quiet && $urandom_range(0, 99) < snd_pct) snd_gap = $urandom_range(1, 14);
      end

      // hold, idle or present the next item
      if (in_if.valid && !took) begin
        // hold the current item
      end else if (n_issued == n_total) begin
        in_if.valid <= 1'b0;
      end else if (snd_gap > 0 && !quiet) begin
        snd_gap--;
        in_if.valid <= 1'b0;
      end else if (n_issued == pause_at && !paused && exp_q.size() != 0) begin
        // wait until every result has come back
        in_if.valid <= 1'b0;
      end else begin
        if (n_issued == pause_at) paused = 1'b1;
        if (n_issued < dir_q.size()) begin
          cur_op = dir_q[n_issued];
        end else begin
          if ((n_issued - dir_q.size()) % PHASE_LEN == 0) begin
            mix_phase = mix_e'($urandom_range(0, 2));
            snd_pct   = pick_pct();
            rcv_pct   = pick_pct();
          end
          pick_op(nm, nv);
          cur_op       = '0;
          cur_op.mode  = mode_e'(nm);
          cur_op.value = nv;
          cur_op.reps  = 8'd1;
          cur_op.chk   = 1'b0;
        end
        in_if.mode  <= cur_op.mode;
        in_if.value <= cur_op.value;
        in_if.valid <= 1'b1;
        n_issued++;
      end
    end
  end

endmodule
